// ===== sv/sstw_pkg.sv =====
// Shared types, codes and segment table for the two-wire seven-segment driver.
`default_nettype none
package sstw_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int DIGIT_IDX_W = $clog2(DIGIT_COUNT);
    localparam int KIND_W      = 2;
    localparam int NUMBER_W    = 14;
    localparam int LEVEL_W     = 3;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 8;

    // Command kinds carried on tuser; the unused code acts as a tick
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SHOW   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BRIGHT = 2'd2;

    // Display controller command bytes
    localparam logic [7:0] CMD_AUTO_INC = 8'h40;
    localparam logic [7:0] CMD_ADDRESS  = 8'hC0;
    localparam logic [7:0] CMD_DISPLAY  = 8'h88;

    typedef logic [DIGIT_COUNT-1:0][7:0] t_seg_store;

    // Pin levels and busy flag after one step
    typedef struct packed {
        logic clk;
        logic dio;
        logic busy;
    } t_pins;

    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] seg;
        unique case (digit)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h6F;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage
`default_nettype wire

// ===== sv/sstw_digits.sv =====
// Decimal digit split of the shown value and segment store, three pipelined steps.
`default_nettype none
module sstw_digits (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_load,
    input  wire logic [sstw_pkg::NUMBER_W-1:0] i_number,
    output sstw_pkg::t_seg_store          o_seg
);
    import sstw_pkg::*;

    logic [2:0]          r_vld;
    logic [NUMBER_W-1:0] r_num;
    logic [9:0]          r_rem1;
    logic [3:0]          r_d0;
    logic [6:0]          r_rem2;
    logic [3:0]          r_d1;
    t_seg_store          r_seg;

    // thousands: n * 8389 >> 23 is exact for n < 16384
    logic [27:0]         w_p1;
    logic [4:0]          w_q1;
    logic [13:0]         w_r1;
    logic [3:0]          w_d0;
    // hundreds: r * 41 >> 12 is exact for r < 1000
    logic [15:0]         w_p2;
    logic [3:0]          w_q2;
    logic [9:0]          w_r2;
    // tens: r * 205 >> 11 is exact for r < 100
    logic [14:0]         w_p3;
    logic [3:0]          w_q3;
    logic [6:0]          w_u;

    always_comb begin
        w_p1 = 28'(r_num) * 28'd8389;
        w_q1 = w_p1[27:23];
        w_r1 = r_num - 14'(14'(w_q1) * 14'd1000);
        w_d0 = (w_q1 >= 5'd10) ? 4'(w_q1 - 5'd10) : w_q1[3:0];

        w_p2 = 16'(r_rem1) * 16'd41;
        w_q2 = w_p2[15:12];
        w_r2 = r_rem1 - 10'(10'(w_q2) * 10'd100);

        w_p3 = 15'(r_rem2) * 15'd205;
        w_q3 = w_p3[14:11];
        w_u  = r_rem2 - 7'(7'(w_q3) * 7'd10);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_load};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_num <= i_number;
        end
        if (r_vld[0]) begin
            r_rem1 <= w_r1[9:0];
            r_d0   <= w_d0;
        end
        if (r_vld[1]) begin
            r_rem2 <= w_r2[6:0];
            r_d1   <= w_q2;
        end
        if (r_vld[2]) begin
            r_seg[0] <= seg_of(r_d0);
            r_seg[1] <= seg_of(r_d1);
            r_seg[2] <= seg_of(w_q3);
            r_seg[3] <= seg_of(w_u[3:0]);
        end
    end

    assign o_seg = r_seg;

endmodule
`default_nettype wire

// ===== sv/sstw_seq.sv =====
// Bus waveform sequencer: start, bytes with acknowledge slots, stop.
`default_nettype none
module sstw_seq (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_fire,
    input  wire logic [sstw_pkg::KIND_W-1:0]  i_kind,
    input  wire logic [sstw_pkg::LEVEL_W-1:0] i_level,
    input  wire sstw_pkg::t_seg_store        i_seg,
    output sstw_pkg::t_pins                  o_pins,
    output logic                             o_load_show
);
    import sstw_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START_HIGH,
        ST_START_LOW,
        ST_BIT_LOW,
        ST_BIT_HIGH,
        ST_ACK_LOW,
        ST_ACK_HIGH,
        ST_STOP_CLK,
        ST_STOP_DIO,
        ST_STOP_RISE,
        ST_STOP_END
    } t_step;

    t_step       r_step, n_step;
    logic [7:0]  r_shift, n_shift;
    logic [3:0]  r_bc, n_bc;
    logic [2:0]  r_bi, n_bi;
    logic        r_bm, n_bm;
    logic        r_clk, n_clk;
    logic        r_dio, n_dio;

    logic        w_idle;
    logic        w_cmd;
    logic [3:0]  w_bc_inc;
    logic [2:0]  w_bi_inc;
    logic [2:0]  w_sel;

    assign w_idle   = (r_step == ST_IDLE);
    assign w_cmd    = (i_kind == KIND_SHOW) || (i_kind == KIND_BRIGHT);
    assign w_bc_inc = r_bc + 4'd1;
    assign w_bi_inc = r_bi + 3'd1;
    assign w_sel    = w_bi_inc - 3'd2;

    always_comb begin
        n_step  = r_step;
        n_shift = r_shift;
        n_bc    = r_bc;
        n_bi    = r_bi;
        n_bm    = r_bm;
        n_clk   = r_clk;
        n_dio   = r_dio;
        if (w_cmd) begin
            // commands while busy are dropped
            if (w_idle) begin
                n_bi   = 3'd0;
                n_bc   = 4'd0;
                n_step = ST_START_HIGH;
                if (i_kind == KIND_SHOW) begin
                    n_bm    = 1'b0;
                    n_shift = CMD_AUTO_INC;
                end else begin
                    n_bm    = 1'b1;
                    n_shift = CMD_DISPLAY | 8'(i_level);
                end
            end
        end else begin
            unique case (r_step)
                ST_START_HIGH: begin
                    n_clk  = 1'b1;
                    n_dio  = 1'b1;
                    n_step = ST_START_LOW;
                end
                ST_START_LOW: begin
                    n_dio  = 1'b0;
                    n_bc   = 4'd0;
                    n_step = ST_BIT_LOW;
                end
                ST_BIT_LOW: begin
                    n_clk  = 1'b0;
                    n_dio  = r_shift[0];
                    n_step = ST_BIT_HIGH;
                end
                ST_BIT_HIGH: begin
                    n_clk   = 1'b1;
                    n_shift = {1'b0, r_shift[7:1]};
                    n_bc    = w_bc_inc;
                    n_step  = (w_bc_inc >= 4'd8) ? ST_ACK_LOW : ST_BIT_LOW;
                end
                ST_ACK_LOW: begin
                    n_clk  = 1'b0;
                    n_dio  = 1'b1;
                    n_step = ST_ACK_HIGH;
                end
                ST_ACK_HIGH: begin
                    n_clk = 1'b1;
                    if (r_bm || r_bi == 3'd0 || r_bi >= 3'(DIGIT_COUNT + 1)) begin
                        n_step = ST_STOP_CLK;
                    end else begin
                        n_bi    = w_bi_inc;
                        n_shift = (w_bi_inc == 3'd1) ? CMD_ADDRESS
                                                     : i_seg[w_sel[DIGIT_IDX_W-1:0]];
                        n_bc    = 4'd0;
                        n_step  = ST_BIT_LOW;
                    end
                end
                ST_STOP_CLK: begin
                    n_clk  = 1'b0;
                    n_step = ST_STOP_DIO;
                end
                ST_STOP_DIO: begin
                    n_dio  = 1'b0;
                    n_step = ST_STOP_RISE;
                end
                ST_STOP_RISE: begin
                    n_clk = 1'b1;
                    // first frame of a show command chains into the address frame
                    if (!r_bm && r_bi == 3'd0) begin
                        n_bi    = 3'd1;
                        n_shift = CMD_ADDRESS;
                        n_step  = ST_START_HIGH;
                    end else begin
                        n_step = ST_STOP_END;
                    end
                end
                ST_STOP_END: begin
                    n_dio  = 1'b1;
                    n_step = ST_IDLE;
                end
                ST_IDLE: begin
                    n_step = ST_IDLE;
                end
                default: begin
                    n_step = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= ST_IDLE;
            r_shift <= '0;
            r_bc    <= '0;
            r_bi    <= '0;
            r_bm    <= 1'b0;
            r_clk   <= 1'b1;
            r_dio   <= 1'b1;
        end else if (i_fire) begin
            r_step  <= n_step;
            r_shift <= n_shift;
            r_bc    <= n_bc;
            r_bi    <= n_bi;
            r_bm    <= n_bm;
            r_clk   <= n_clk;
            r_dio   <= n_dio;
        end
    end

    assign o_pins.clk   = n_clk;
    assign o_pins.dio   = n_dio;
    assign o_pins.busy  = (n_step != ST_IDLE);
    assign o_load_show  = i_fire && w_idle && (i_kind == KIND_SHOW);

    // bus is released high whenever no sequence runs
    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_IDLE) |-> (r_clk && r_dio))
        else $error("pins not released while idle");
    a_bit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bc <= 4'd8)
        else $error("bit count overran a byte");
    a_byte_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bi <= 3'(DIGIT_COUNT + 1))
        else $error("byte index past last digit");
    a_bright_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != ST_IDLE && r_bm) |-> (r_bi == 3'd0))
        else $error("brightness frame advanced byte index");

endmodule
`default_nettype wire

// ===== sv/seven_segment_two_wire_display_driver_unit.sv =====
// Top level: stream ports, input and result registers around the sequencer.
`default_nettype none
// An input transaction reaches the master side through the input register, then the
//   sequencer step into the result register.
// Throughput: one transaction per cycle, set by the single sequencer step per item;
//   a stalled result holds the sequencer, the input register fills and tready drops.
// Reset (i_rst_n low, synchronous): sequencer idle, both pins high, no data held.
// Show commands fill the segment store via the digit pipeline well before its first read.
module seven_segment_two_wire_display_driver_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // slave side
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [sstw_pkg::IN_DATA_W-1:0] i_s_tdata,  // [13:0] number, [16:14] level
    input  wire logic [sstw_pkg::KIND_W-1:0]    i_s_tuser,  // [1:0] kind
    // master side
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [sstw_pkg::OUT_DATA_W-1:0]    o_m_tdata   // [0] clk_level, [1] dio_level,
                                                           // [2] busy_res
);
    import sstw_pkg::*;

    // input register
    logic                r_in_valid;
    logic [KIND_W-1:0]   r_kind;
    logic [NUMBER_W-1:0] r_number;
    logic [LEVEL_W-1:0]  r_level;

    // result register
    logic                r_out_valid;
    t_pins               r_out_pins;

    logic                w_fire;
    logic                w_load_show;
    t_pins               w_pins;
    t_seg_store          w_seg;

    // one item steps the sequencer when the result register can take its result
    assign w_fire     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_kind   <= i_s_tuser;
            r_number <= i_s_tdata[NUMBER_W-1:0];
            r_level  <= i_s_tdata[NUMBER_W +: LEVEL_W];
        end
        if (w_fire) begin
            r_out_pins <= w_pins;
        end
    end

    sstw_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_kind      (r_kind),
        .i_level     (r_level),
        .i_seg       (w_seg),
        .o_pins      (w_pins),
        .o_load_show (w_load_show)
    );

    sstw_digits u_digits (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load_show),
        .i_number (r_number),
        .o_seg    (w_seg)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out_pins.busy, r_out_pins.dio, r_out_pins.clk};

endmodule
`default_nettype wire
